[rtl/core/pixel_framebuffer_dirty_refresh_assert.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the pixel frame buffer
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// -----------------------------------------------------------------------------
`ifndef PIXEL_FRAMEBUFFER_DIRTY_REFRESH_ASSERT_SVH
`define PIXEL_FRAMEBUFFER_DIRTY_REFRESH_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is low.
`define PFDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define PFDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PFDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PFDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[rtl/core/pfdr_pkg.sv]
// -----------------------------------------------------------------------------
// Pixel frame buffer package
// Geometry, field codes, display command bytes and the command record.
// -----------------------------------------------------------------------------
`default_nettype none

package pfdr_pkg;

  localparam int unsigned COLUMNS    = 128;
  localparam int unsigned PAGES      = 8;
  localparam int unsigned DEPTH      = PAGES * COLUMNS;
  localparam int unsigned COL_W      = $clog2(COLUMNS);
  localparam int unsigned PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned SCAN_W     = $clog2(PAGES + 1);
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // Request function codes.
  localparam logic [1:0] FUNC_DRAW    = 2'd0;
  localparam logic [1:0] FUNC_CLEAR   = 2'd1;
  localparam logic [1:0] FUNC_REFRESH = 2'd2;

  // Display command bytes.
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] COL_LO_MASK   = 8'h0F;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;
  localparam logic [7:0] WIN_EMPTY     = 8'hFF;

  typedef enum logic [1:0] {
    OP_DRAW,
    OP_CLEAR,
    OP_REFRESH
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [PAGE_W-1:0] page;
    logic [COL_W-1:0]  col;
    logic [7:0]        mask;
    logic              on;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] frame_addr(input logic [PAGE_W-1:0] page,
                                                   input logic [COL_W-1:0]  col);
    return ADDR_W'(page) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

[rtl/core/pfdr_front.sv]
// -----------------------------------------------------------------------------
// Pixel frame buffer front end
// Accepts requests, drops ignored ones and maps draw coordinates to page,
// column and bit mask.
// -----------------------------------------------------------------------------
`default_nettype none

module pfdr_front (
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        func_i,
  input  wire logic [7:0]        pixel_x_i,
  input  wire logic [7:0]        pixel_y_i,
  input  wire logic              pixel_on_i,
  input  wire logic              cmdq_full_i,
  input  wire logic              init_busy_i,
  output logic                   cmd_push_o,
  output pfdr_pkg::cmd_t         cmd_o
);

  logic       accept;
  logic       in_range;
  logic [7:0] page_full;

  assign full   = cmdq_full_i | init_busy_i;
  assign accept = push & ~full;

  assign in_range = (pixel_x_i <= 8'(pfdr_pkg::COLUMNS - 1)) &&
                    (pixel_y_i <= 8'(pfdr_pkg::PAGES * 8 - 1));

  // Rows are stored bottom page first and with the bit order flipped.
  assign page_full = 8'(pfdr_pkg::PAGES - 1) - (pixel_y_i >> 3);

  always_comb begin
    cmd_o.op   = pfdr_pkg::OP_DRAW;
    cmd_o.page = page_full[pfdr_pkg::PAGE_W-1:0];
    cmd_o.col  = pixel_x_i[pfdr_pkg::COL_W-1:0];
    cmd_o.mask = 8'h80 >> pixel_y_i[2:0];
    cmd_o.on   = pixel_on_i;
    cmd_push_o = 1'b0;
    unique case (func_i)
      pfdr_pkg::FUNC_DRAW: begin
        cmd_push_o = accept & in_range;
      end
      pfdr_pkg::FUNC_CLEAR: begin
        cmd_o.op   = pfdr_pkg::OP_CLEAR;
        cmd_push_o = accept;
      end
      pfdr_pkg::FUNC_REFRESH: begin
        cmd_o.op   = pfdr_pkg::OP_REFRESH;
        cmd_push_o = accept;
      end
      default: begin
        cmd_push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/pfdr_cmdq.sv]
// -----------------------------------------------------------------------------
// Pixel frame buffer command queue
// Small queue of decoded requests between the front end and the engine.
// -----------------------------------------------------------------------------
`default_nettype none

module pfdr_cmdq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pfdr_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output pfdr_pkg::cmd_t      cmd_o
);

  pfdr_pkg::cmd_t                  entry_q [pfdr_pkg::CMDQ_DEPTH];
  logic [pfdr_pkg::CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [pfdr_pkg::CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [pfdr_pkg::CMDQ_PTR_W:0]   count_q, count_d;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == (pfdr_pkg::CMDQ_PTR_W+1)'(pfdr_pkg::CMDQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pfdr_back.sv]
// -----------------------------------------------------------------------------
// Pixel frame buffer engine
// Owns the frame memory, page dirty flags and column windows; executes
// draw, clear and refresh commands and queues the refresh bytes.
// -----------------------------------------------------------------------------
`default_nettype none

module pfdr_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire pfdr_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                init_busy_o,
  output logic                empty,
  input  wire logic           pop,
  output logic [7:0]          out_byte_o,
  output logic                is_data_o,
  output logic                scan_done_o
);

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_DRAW  = 5'b00100,
    ST_CLEAR = 5'b01000,
    ST_REF   = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    PH_CMD,
    PH_COL_LO,
    PH_COL_HI,
    PH_DATA
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_data;
    logic       done;
  } res_t;

  state_e state_q, state_d;

  // Frame memory.
  logic [7:0]                  mem_q [pfdr_pkg::DEPTH];
  logic                        mem_we, mem_re;
  logic [pfdr_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]                  rdata_q;
  logic [7:0]                  draw_after;

  // Page tracking.
  logic [pfdr_pkg::PAGES-1:0]  dirty_q;
  logic [7:0]                  win_first_q [pfdr_pkg::PAGES];
  logic [pfdr_pkg::COL_W-1:0]  win_last_q  [pfdr_pkg::PAGES];
  logic [pfdr_pkg::PAGE_W-1:0] win_idx;
  logic [7:0]                  wf;
  logic [pfdr_pkg::COL_W-1:0]  wl;
  logic                        widen_en, done_en;
  logic [pfdr_pkg::COL_W-1:0]  widen_col;

  // Refresh scan.
  logic [pfdr_pkg::SCAN_W-1:0] scan_page_q, scan_page_d;
  phase_e                      phase_q, phase_d;
  logic [pfdr_pkg::COL_W-1:0]  scan_col_q, scan_col_d;
  logic                        found;
  logic [pfdr_pkg::PAGE_W-1:0] found_page;

  // Sweep counters for the clear command; the address counter also serves the power-up clear.
  logic [pfdr_pkg::ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic [pfdr_pkg::PAGE_W-1:0] clr_page_q, clr_page_d;
  logic [pfdr_pkg::COL_W-1:0]  clr_col_q, clr_col_d;
  logic                        clr_run_q, clr_run_d;
  logic                        chk_valid_q, chk_valid_d;
  logic [pfdr_pkg::ADDR_W-1:0] chk_addr_q, chk_addr_d;
  logic [pfdr_pkg::PAGE_W-1:0] chk_page_q, chk_page_d;
  logic [pfdr_pkg::COL_W-1:0]  chk_col_q, chk_col_d;

  pfdr_pkg::cmd_t cmd_q, cmd_d;

  // Result queue.
  res_t       res_q [2];
  logic       res_wr_q, res_rd_q;
  logic [1:0] res_cnt_q;
  logic       res_push, res_pop;
  res_t       res_in;

  assign init_busy_o = (state_q == ST_INIT);
  assign wf          = win_first_q[win_idx];
  assign wl          = win_last_q[win_idx];
  assign draw_after  = cmd_q.on ? (rdata_q | cmd_q.mask) : (rdata_q & ~cmd_q.mask);

  // Lowest dirty page at or above the scan position.
  always_comb begin
    found      = 1'b0;
    found_page = '0;
    for (int i = pfdr_pkg::PAGES - 1; i >= 0; i--) begin
      if (dirty_q[i] && (pfdr_pkg::SCAN_W'(i) >= scan_page_q)) begin
        found      = 1'b1;
        found_page = pfdr_pkg::PAGE_W'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cmd_pop_o   = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = clr_addr_q;
    mem_raddr   = clr_addr_q;
    widen_en    = 1'b0;
    widen_col   = cmd_q.col;
    done_en     = 1'b0;
    win_idx     = scan_page_q[pfdr_pkg::PAGE_W-1:0];
    res_push    = 1'b0;
    res_in      = '0;
    scan_page_d = scan_page_q;
    phase_d     = phase_q;
    scan_col_d  = scan_col_q;
    clr_addr_d  = clr_addr_q;
    clr_page_d  = clr_page_q;
    clr_col_d   = clr_col_q;
    clr_run_d   = clr_run_q;
    chk_valid_d = 1'b0;
    chk_addr_d  = chk_addr_q;
    chk_page_d  = chk_page_q;
    chk_col_d   = chk_col_q;

    unique case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        if (clr_addr_q == pfdr_pkg::ADDR_W'(pfdr_pkg::DEPTH - 1)) begin
          clr_addr_d = '0;
          state_d    = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            pfdr_pkg::OP_DRAW: begin
              cmd_pop_o = 1'b1;
              cmd_d     = cmd_i;
              mem_re    = 1'b1;
              mem_raddr = pfdr_pkg::frame_addr(cmd_i.page, cmd_i.col);
              state_d   = ST_DRAW;
            end
            pfdr_pkg::OP_CLEAR: begin
              cmd_pop_o  = 1'b1;
              clr_addr_d = '0;
              clr_page_d = '0;
              clr_col_d  = '0;
              clr_run_d  = 1'b1;
              state_d    = ST_CLEAR;
            end
            pfdr_pkg::OP_REFRESH: begin
              // Take a refresh only when its byte has a place in the result queue.
              if (res_cnt_q != 2'd2) begin
                cmd_pop_o = 1'b1;
                case (phase_q)
                  PH_CMD: begin
                    res_push = 1'b1;
                    if (found) begin
                      scan_page_d = pfdr_pkg::SCAN_W'(found_page);
                      phase_d     = PH_COL_LO;
                      res_in.data = pfdr_pkg::CMD_PAGE_BASE + 8'(found_page);
                    end else begin
                      scan_page_d = '0;
                      res_in.done = 1'b1;
                    end
                  end
                  PH_COL_LO: begin
                    res_push    = 1'b1;
                    res_in.data = wf & pfdr_pkg::COL_LO_MASK;
                    phase_d     = PH_COL_HI;
                  end
                  PH_COL_HI: begin
                    res_push    = 1'b1;
                    res_in.data = (wf >> 4) | pfdr_pkg::CMD_COL_HI;
                    if ((wf > 8'(wl)) || (wf >= 8'(pfdr_pkg::COLUMNS))) begin
                      // Dirty page with an empty window: no data bytes.
                      done_en     = 1'b1;
                      phase_d     = PH_CMD;
                      scan_page_d = scan_page_q + 1'b1;
                    end else begin
                      scan_col_d = wf[pfdr_pkg::COL_W-1:0];
                      phase_d    = PH_DATA;
                    end
                  end
                  default: begin
                    mem_re    = 1'b1;
                    mem_raddr = pfdr_pkg::frame_addr(scan_page_q[pfdr_pkg::PAGE_W-1:0],
                                                     scan_col_q);
                    state_d   = ST_REF;
                  end
                endcase
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end

      ST_DRAW: begin
        win_idx   = cmd_q.page;
        mem_waddr = pfdr_pkg::frame_addr(cmd_q.page, cmd_q.col);
        if (draw_after != rdata_q) begin
          mem_we   = 1'b1;
          widen_en = 1'b1;
        end
        state_d = ST_IDLE;
      end

      ST_CLEAR: begin
        // Read one byte per cycle; the byte read last cycle is checked and zeroed.
        if (clr_run_q) begin
          mem_re      = 1'b1;
          chk_valid_d = 1'b1;
          chk_addr_d  = clr_addr_q;
          chk_page_d  = clr_page_q;
          chk_col_d   = clr_col_q;
          clr_addr_d  = clr_addr_q + 1'b1;
          if (clr_col_q == pfdr_pkg::COL_W'(pfdr_pkg::COLUMNS - 1)) begin
            clr_col_d  = '0;
            clr_page_d = clr_page_q + 1'b1;
            if (clr_page_q == pfdr_pkg::PAGE_W'(pfdr_pkg::PAGES - 1)) begin
              clr_run_d = 1'b0;
            end
          end else begin
            clr_col_d = clr_col_q + 1'b1;
          end
        end
        win_idx   = chk_page_q;
        widen_col = chk_col_q;
        mem_waddr = chk_addr_q;
        if (chk_valid_q && (rdata_q != 8'h00)) begin
          mem_we   = 1'b1;
          widen_en = 1'b1;
        end
        if (!clr_run_q && !chk_valid_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_REF: begin
        res_push       = 1'b1;
        res_in.data    = rdata_q;
        res_in.is_data = 1'b1;
        if (scan_col_q >= wl) begin
          done_en     = 1'b1;
          phase_d     = PH_CMD;
          scan_page_d = scan_page_q + 1'b1;
        end else begin
          scan_col_d = scan_col_q + 1'b1;
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      scan_page_q <= '0;
      phase_q     <= PH_CMD;
      scan_col_q  <= '0;
      clr_addr_q  <= '0;
      clr_page_q  <= '0;
      clr_col_q   <= '0;
      clr_run_q   <= 1'b0;
      chk_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_page_q <= scan_page_d;
      phase_q     <= phase_d;
      scan_col_q  <= scan_col_d;
      clr_addr_q  <= clr_addr_d;
      clr_page_q  <= clr_page_d;
      clr_col_q   <= clr_col_d;
      clr_run_q   <= clr_run_d;
      chk_valid_q <= chk_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    chk_addr_q <= chk_addr_d;
    chk_page_q <= chk_page_d;
    chk_col_q  <= chk_col_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= 8'h00 | (state_q == ST_DRAW ? draw_after : 8'h00);
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pfdr_pkg::PAGES; i++) begin
        dirty_q[i]     <= 1'b1;
        win_first_q[i] <= '0;
        win_last_q[i]  <= pfdr_pkg::COL_W'(pfdr_pkg::COLUMNS - 1);
      end
    end else if (widen_en) begin
      dirty_q[win_idx] <= 1'b1;
      if (8'(widen_col) < wf) begin
        win_first_q[win_idx] <= 8'(widen_col);
      end
      if (widen_col > wl) begin
        win_last_q[win_idx] <= widen_col;
      end
    end else if (done_en) begin
      dirty_q[win_idx]     <= 1'b0;
      win_first_q[win_idx] <= pfdr_pkg::WIN_EMPTY;
      win_last_q[win_idx]  <= '0;
    end
  end

  assign empty       = (res_cnt_q == 2'd0);
  assign res_pop     = pop & ~empty;
  assign out_byte_o  = res_q[res_rd_q].data;
  assign is_data_o   = res_q[res_rd_q].is_data;
  assign scan_done_o = res_q[res_rd_q].done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr_q <= ~res_wr_q;
      end
      if (res_pop) begin
        res_rd_q <= ~res_rd_q;
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + 2'd1;
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q[res_wr_q] <= res_in;
    end
  end

endmodule

`default_nettype wire

[rtl/core/pixel_framebuffer_dirty_refresh.sv]
// -----------------------------------------------------------------------------
// Pixel frame buffer with dirty page refresh
// A 128x64 monochrome page frame store with per-page dirty flags and changed
// column windows, fed through a request queue and read out as a byte stream
// of page and column commands followed by window data. Requests enter a
// four-deep command queue; the engine then takes a draw as a read and write
// back of one frame byte, a refresh command byte directly from idle, a
// refresh data byte through a registered memory read, and a clear as a
// sweep of the frame, one frame byte per cycle through the single write
// port. After reset the engine zeroes the frame memory, one byte per cycle,
// and holds full high meanwhile. Results leave through a two-entry queue,
// so the engine keeps working while a byte waits for pop.
// -----------------------------------------------------------------------------
`default_nettype none

`include "pixel_framebuffer_dirty_refresh_assert.svh"

module pixel_framebuffer_dirty_refresh (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] func_i,
  input  wire logic [7:0] pixel_x_i,
  input  wire logic [7:0] pixel_y_i,
  input  wire logic       pixel_on_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            is_data_o,
  output logic            scan_done_o
);

  pfdr_pkg::cmd_t front_cmd;
  pfdr_pkg::cmd_t queued_cmd;
  logic           cmd_push;
  logic           cmdq_full;
  logic           cmd_valid;
  logic           cmd_pop;
  logic           init_busy;

  pfdr_front u_front (
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .pixel_on_i  (pixel_on_i),
    .cmdq_full_i (cmdq_full),
    .init_busy_i (init_busy),
    .cmd_push_o  (cmd_push),
    .cmd_o       (front_cmd)
  );

  pfdr_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (front_cmd),
    .full_o  (cmdq_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .cmd_o   (queued_cmd)
  );

  pfdr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (queued_cmd),
    .cmd_pop_o   (cmd_pop),
    .init_busy_o (init_busy),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .is_data_o   (is_data_o),
    .scan_done_o (scan_done_o)
  );

  // No request may slip in while the memory is still being zeroed.
  `PFDR_ASSERT_IMP(a_init_blocks, clk_i, rst_ni, init_busy, full && !cmd_push, "request during init")
  // The front end only forwards into a queue with room.
  `PFDR_ASSERT_IMP(a_cmdq_room, clk_i, rst_ni, cmd_push, !cmdq_full, "push into full queue")
  // After a forwarded request the engine sees a valid command on the next cycle.
  `PFDR_ASSERT_NXT(a_cmdq_visible, clk_i, rst_ni, cmd_push, cmd_valid, "queued command lost")
  // A scan-done result carries no byte.
  `PFDR_ASSERT_IMP(a_done_clean, clk_i, rst_ni, !empty && scan_done_o, out_byte_o == 8'h00 && !is_data_o, "done result carries a byte")

endmodule

`default_nettype wire
